### design/bcdc_pkg.sv
package bcdc_pkg;

    localparam int W_OMEGA    = 16;
    localparam int W_FIELD    = 18;
    localparam int W_MOM      = 32;
    localparam int W_IN_DATA  = 104;
    localparam int W_OUT_DATA = 96;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;

    localparam logic [W_CFG_IDX-1:0] CFG_MODE  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN  = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_LIM_X = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_LIM_Y = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_LIM_Z = 3'd4;

    localparam logic [1:0] MODE_PROJ = 2'd0;
    localparam logic [1:0] MODE_BANG = 2'd1;
    localparam logic [1:0] MODE_DIR  = 2'd2;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

### design/bcdc_isqrt.sv
module bcdc_isqrt #(
    parameter int XW = 36,
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bcdc_pkg::pipe_ctl_t     ctl,
    input  logic [XW-1:0]           x,
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic [(XW+1)/2-1:0]     root,
    output logic [SW-1:0]           side_out
);
    import bcdc_pkg::*;

    localparam int RW = (XW + 1) / 2;

    logic          vld_reg  [RW];
    logic [XW-1:0] x_reg    [RW];
    logic [XW:0]   res_reg  [RW];
    logic [SW-1:0] side_reg [RW];

    // one result bit per stage, classic shift-and-subtract root
    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic          vld_in;
        logic [XW-1:0] x_in;
        logic [XW:0]   res_in;
        logic [SW-1:0] sd_in;
        logic [XW:0]   bitv;
        logic [XW:0]   trial;
        logic [XW-1:0] x_next;
        logic [XW:0]   res_next;

        if (s == 0)
        begin : g_first
            assign vld_in = ctl.valid;
            assign x_in   = x;
            assign res_in = '0;
            assign sd_in  = side_in;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[s-1];
            assign x_in   = x_reg[s-1];
            assign res_in = res_reg[s-1];
            assign sd_in  = side_reg[s-1];
        end

        assign bitv  = (XW+1)'(1) << (2 * (RW - 1 - s));
        assign trial = res_in + bitv;

        always_comb
        begin
            if ({1'b0, x_in} >= trial)
            begin
                x_next   = x_in - trial[XW-1:0];
                res_next = (res_in >> 1) + bitv;
            end
            else
            begin
                x_next   = x_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (ctl.en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[s]    <= x_next;
                res_reg[s]  <= res_next;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = res_reg[RW-1][RW-1:0];
    assign side_out  = side_reg[RW-1];

endmodule

### design/bcdc_div.sv
module bcdc_div #(
    parameter int LANES = 3,
    parameter int NW    = 64,
    parameter int DW    = 36,
    parameter int QW    = 30,
    parameter int SW    = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcdc_pkg::pipe_ctl_t         ctl,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [DW-1:0]               den,
    input  logic [SW-1:0]               side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quo,
    output logic [SW-1:0]               side_out
);
    import bcdc_pkg::*;

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic                     vld_reg  [QW];
    logic [LANES-1:0][NW-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0] q_reg    [QW];
    logic [DW-1:0]            den_reg  [QW];
    logic [SW-1:0]            side_reg [QW];

    // restoring division, one quotient bit per stage, lanes share the divisor
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic                     vld_in;
        logic [LANES-1:0][NW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] q_in;
        logic [DW-1:0]            den_in;
        logic [SW-1:0]            sd_in;
        logic [CW-1:0]            dsh;
        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] q_next;

        if (s == 0)
        begin : g_first
            assign vld_in = ctl.valid;
            assign rem_in = num;
            assign q_in   = '0;
            assign den_in = den;
            assign sd_in  = side_in;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
            assign sd_in  = side_reg[s-1];
        end

        assign dsh = CW'(den_in) << (QW - 1 - s);

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (CW'(rem_in[l]) >= dsh)
                begin
                    rem_next[l] = NW'(CW'(rem_in[l]) - dsh);
                    q_next[l]   = QW'({q_in[l], 1'b1});
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    q_next[l]   = QW'({q_in[l], 1'b0});
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (ctl.en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

### design/b_cross_detumble_controller_top.sv
// magnetorquer detumble controller, b-cross family of laws
// input channel s_axis: one word holds a body rate vector and a field vector
// output channel m_axis: one word per input word, three dipole commands in
// tdata and the zero-field flag in tuser
// configuration: cfg_we / cfg_index / cfg_data, which the user must write only while idle
// (the block does not enforce this); index 0 mode, 1 gain, 2..4 axis limits
// the word passes through 77 register stages on its way to m_axis_tvalid:
// 4 product stages, 18 stages of the square root, 1 divider
// operand stage, 30 stages of the first divider (one quotient bit each), 7 gain
// and axis-select stages, 16 stages of the scaling divider and the output register
// throughput is one word per cycle while the receiver does not stall; every stage
// is a register with a valid bit and the whole pipeline advances together
// when the receiver stalls with a word waiting, the pipeline freezes and
// s_axis_tready drops; nothing is dropped or repeated
// reset clears all valid bits and loads mode 2, gain 1.0 and the default limits
module b_cross_detumble_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // omega_x, omega_y, omega_z, field_x, field_y, field_z, 2 zero bits
    input  logic [bcdc_pkg::W_IN_DATA-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // moment_x, moment_y, moment_z
    output logic [bcdc_pkg::W_OUT_DATA-1:0]     m_axis_tdata,
    // field_zero
    output logic                                m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [bcdc_pkg::W_CFG_IDX-1:0]      cfg_index,
    input  logic [bcdc_pkg::W_CFG_DATA-1:0]     cfg_data
);
    import bcdc_pkg::*;

    localparam logic [13:0] K_MOM = 14'd15625;

    typedef struct packed {
        logic             zero;
        logic [35:0]      n2;
        logic [2:0][15:0] w;
        logic [2:0][33:0] c;
        logic [2:0][52:0] bd;
    } sq_side_t;

    typedef struct packed {
        logic             zero;
        logic [2:0]       cneg;
        logic [2:0]       neg;
        logic [2:0][15:0] w;
    } d1_side_t;

    typedef struct packed {
        logic             zero;
        logic             usediv;
        logic [2:0]       tneg;
        logic [2:0][31:0] alt;
    } d2_side_t;

    function automatic logic [31:0] sat_mag(input logic [41:0] m, input logic neg);
        logic [31:0] r;
        if (!neg)
            r = (m > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        else
            r = (m > 42'h0_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
        return r;
    endfunction

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] gain_reg;
    logic [15:0] lim_reg [3];
    logic [15:0] lim_eff [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DIR;
            gain_reg   <= 32'd65536;
            lim_reg[0] <= 16'd8800;
            lim_reg[1] <= 16'd13720;
            lim_reg[2] <= 16'd8200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg   <= cfg_data[1:0];
                CFG_GAIN:  gain_reg   <= cfg_data;
                CFG_LIM_X: lim_reg[0] <= cfg_data[15:0];
                CFG_LIM_Y: lim_reg[1] <= cfg_data[15:0];
                CFG_LIM_Z: lim_reg[2] <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            lim_eff[i] = (lim_reg[i] == 16'd0) ? 16'd1 : lim_reg[i];
    end

    logic en;
    logic out_vld_reg;
    pipe_ctl_t ctl1, ctl2;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // s1: input word
    logic              v1_reg;
    logic signed [15:0] w1_reg [3];
    logic signed [17:0] b1_reg [3];
    // s2: partial products
    logic              v2_reg;
    logic signed [33:0] pwb_reg [3][3];
    logic [34:0]       bb_reg [3];
    logic signed [17:0] b2_reg [3];
    logic signed [15:0] w2_reg [3];
    // s3: cross product, dot product, squared norm
    logic              v3_reg;
    logic signed [33:0] c3_reg [3];
    logic signed [34:0] d3_reg;
    logic [35:0]       n2_3_reg;
    logic signed [17:0] b3_reg [3];
    logic signed [15:0] w3_reg [3];
    // s4: b_i * d
    logic              v4_reg;
    logic signed [52:0] bd4_reg [3];
    logic signed [33:0] c4_reg [3];
    logic signed [15:0] w4_reg [3];
    logic [35:0]       n2_4_reg;
    logic              zero4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w1_reg[i] <= s_axis_tdata[16*i +: 16];
                b1_reg[i] <= s_axis_tdata[48+18*i +: 18];
                for (int k = 0; k < 3; k++)
                    pwb_reg[i][k] <= 34'(w1_reg[i]) * 34'(b1_reg[k]);
                bb_reg[i] <= 35'(36'(b1_reg[i]) * 36'(b1_reg[i]));
                w2_reg[i] <= w1_reg[i];
                b2_reg[i] <= b1_reg[i];
                w3_reg[i] <= w2_reg[i];
                b3_reg[i] <= b2_reg[i];
                bd4_reg[i] <= 53'(b3_reg[i]) * 53'(d3_reg);
                c4_reg[i]  <= c3_reg[i];
                w4_reg[i]  <= w3_reg[i];
            end
            c3_reg[0] <= pwb_reg[1][2] - pwb_reg[2][1];
            c3_reg[1] <= pwb_reg[2][0] - pwb_reg[0][2];
            c3_reg[2] <= pwb_reg[0][1] - pwb_reg[1][0];
            d3_reg    <= 35'(pwb_reg[0][0]) + 35'(pwb_reg[1][1]) + 35'(pwb_reg[2][2]);
            n2_3_reg  <= 36'(bb_reg[0]) + 36'(bb_reg[1]) + 36'(bb_reg[2]);
            n2_4_reg  <= n2_3_reg;
            zero4_reg <= (n2_3_reg == 36'd0);
        end
    end

    // square root of |B|^2
    sq_side_t    sq_side_in, sq_side_out;
    logic        sq_vld;
    logic [17:0] norm;

    always_comb
    begin
        sq_side_in.zero = zero4_reg;
        sq_side_in.n2   = n2_4_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq_side_in.w[i]  = w4_reg[i];
            sq_side_in.c[i]  = c4_reg[i];
            sq_side_in.bd[i] = bd4_reg[i];
        end
    end

    assign ctl1.en    = en;
    assign ctl1.valid = v4_reg;

    bcdc_isqrt #(
        .XW (36),
        .SW ($bits(sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl1),
        .x         (n2_4_reg),
        .side_in   (sq_side_in),
        .out_valid (sq_vld),
        .root      (norm),
        .side_out  (sq_side_out)
    );

    // s5: divider operands, projection divides by |B|^2, the others by |B|
    logic             v5_reg;
    logic [2:0][63:0] num5_reg;
    logic [35:0]      den5_reg;
    d1_side_t         d1s5_reg;
    logic [2:0][63:0] num5_next;
    d1_side_t         d1s5_next;
    logic             proj;

    assign proj = (mode_reg == MODE_PROJ);

    always_comb
    begin
        logic signed [52:0] bdv;
        logic signed [33:0] cv;
        logic signed [52:0] bda;
        logic signed [33:0] ca;
        d1s5_next.zero = sq_side_out.zero;
        for (int i = 0; i < 3; i++)
        begin
            bdv = $signed(sq_side_out.bd[i]);
            cv  = $signed(sq_side_out.c[i]);
            bda = bdv[52] ? -bdv : bdv;
            ca  = cv[33] ? -cv : cv;
            d1s5_next.w[i]    = sq_side_out.w[i];
            d1s5_next.cneg[i] = cv[33];
            if (proj)
            begin
                num5_next[i]     = {bda[51:0], 12'd0};
                d1s5_next.neg[i] = bdv[52];
            end
            else
            begin
                num5_next[i]     = 64'({ca[32:0], 12'd0});
                d1s5_next.neg[i] = cv[33];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num5_reg <= num5_next;
            den5_reg <= proj ? sq_side_out.n2 : 36'(norm);
            d1s5_reg <= d1s5_next;
        end
    end

    assign ctl2.en    = en;
    assign ctl2.valid = v5_reg;

    logic             d1_vld;
    logic [2:0][29:0] q1;
    d1_side_t         d1s_out;

    bcdc_div #(
        .LANES (3),
        .NW    (64),
        .DW    (36),
        .QW    (30),
        .SW    ($bits(d1_side_t))
    ) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl2),
        .num       (num5_reg),
        .den       (den5_reg),
        .side_in   (d1s5_reg),
        .out_valid (d1_vld),
        .quo       (q1),
        .side_out  (d1s_out)
    );

    // s6: rate vector in q24
    logic               v6_reg;
    logic signed [31:0] v6_val_reg [3];
    logic [2:0]         cneg6_reg;
    logic               zero6_reg;
    // s7: |v| * gain
    logic               v7_reg;
    logic [61:0]        p7_reg [3];
    logic [2:0]         vneg7_reg;
    logic [2:0]         cneg7_reg;
    logic               zero7_reg;
    // s8: times 10^6 / 2^6, split in halves
    logic               v8_reg;
    logic [44:0]        hp8_reg [3];
    logic [44:0]        lp8_reg [3];
    logic [2:0]         tneg8_reg;
    logic [2:0]         cneg8_reg;
    logic               zero8_reg;
    // s9: moment magnitude
    logic               v9_reg;
    logic [41:0]        tmag9_reg [3];
    logic [2:0]         tneg9_reg;
    logic [2:0]         cneg9_reg;
    logic               zero9_reg;
    // s10: ratio cross products
    logic               v10_reg;
    logic [57:0]        cr10_reg [6];
    logic [41:0]        tmag10_reg [3];
    logic [2:0]         tneg10_reg;
    logic [2:0]         cneg10_reg;
    logic               zero10_reg;

    logic signed [31:0] v6_next [3];
    logic [75:0]        sum9 [3];

    always_comb
    begin
        logic signed [31:0] qs;
        logic signed [31:0] wq;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed(32'(q1[i]));
            if (d1s_out.neg[i])
                qs = -qs;
            wq = 32'($signed(d1s_out.w[i])) <<< 12;
            v6_next[i] = proj ? (wq - qs) : qs;
            sum9[i] = {hp8_reg[i], 31'd0} + 76'(lp8_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg  <= d1_vld;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [31:0] va;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v6_val_reg[i] <= v6_next[i];
                va = v6_val_reg[i][31] ? -v6_val_reg[i] : v6_val_reg[i];
                p7_reg[i]     <= 62'(va[29:0]) * 62'(gain_reg);
                vneg7_reg[i]  <= v6_val_reg[i][31];
                hp8_reg[i]    <= 45'(p7_reg[i][61:31]) * 45'(K_MOM);
                lp8_reg[i]    <= 45'(p7_reg[i][30:0]) * 45'(K_MOM);
                tmag9_reg[i]  <= sum9[i][75:34];
                tmag10_reg[i] <= tmag9_reg[i];
            end
            cneg6_reg  <= d1s_out.cneg;
            zero6_reg  <= d1s_out.zero;
            cneg7_reg  <= cneg6_reg;
            zero7_reg  <= zero6_reg;
            tneg8_reg  <= vneg7_reg;
            cneg8_reg  <= cneg7_reg;
            zero8_reg  <= zero7_reg;
            tneg9_reg  <= tneg8_reg;
            cneg9_reg  <= cneg8_reg;
            zero9_reg  <= zero8_reg;
            tneg10_reg <= tneg9_reg;
            cneg10_reg <= cneg9_reg;
            zero10_reg <= zero9_reg;
            cr10_reg[0] <= 58'(tmag9_reg[1]) * 58'(lim_eff[0]);
            cr10_reg[1] <= 58'(tmag9_reg[0]) * 58'(lim_eff[1]);
            cr10_reg[2] <= 58'(tmag9_reg[2]) * 58'(lim_eff[0]);
            cr10_reg[3] <= 58'(tmag9_reg[0]) * 58'(lim_eff[2]);
            cr10_reg[4] <= 58'(tmag9_reg[2]) * 58'(lim_eff[1]);
            cr10_reg[5] <= 58'(tmag9_reg[1]) * 58'(lim_eff[2]);
        end
    end

    // s11: dominant axis, fallback moments for every law
    logic             v11_reg;
    logic [31:0]      alt11_reg [3];
    logic             usediv11_reg;
    logic [41:0]      den11_reg;
    logic [15:0]      limj11_reg;
    logic [41:0]      tmag11_reg [3];
    logic [2:0]       tneg11_reg;
    logic             zero11_reg;

    logic [41:0]      tj;
    logic [15:0]      lj;
    logic             over;
    logic [31:0]      alt_next [3];
    logic             usediv_next;

    always_comb
    begin
        logic j1;
        logic pick2;
        logic [1:0] jsel;
        j1    = cr10_reg[0] > cr10_reg[1];
        pick2 = j1 ? (cr10_reg[4] > cr10_reg[5]) : (cr10_reg[2] > cr10_reg[3]);
        jsel  = pick2 ? 2'd2 : (j1 ? 2'd1 : 2'd0);
        case (jsel)
            2'd1:
            begin
                tj = tmag10_reg[1];
                lj = lim_eff[1];
            end
            2'd2:
            begin
                tj = tmag10_reg[2];
                lj = lim_eff[2];
            end
            default:
            begin
                tj = tmag10_reg[0];
                lj = lim_eff[0];
            end
        endcase
        over = tj > 42'(lj);
        for (int i = 0; i < 3; i++)
        begin
            case (mode_reg)
                MODE_PROJ: alt_next[i] = sat_mag(tmag10_reg[i], !tneg10_reg[i]);
                MODE_BANG: alt_next[i] = (gain_reg == 32'd0 || !cneg10_reg[i]) ?
                                         32'(lim_eff[i]) : -32'(lim_eff[i]);
                default:   alt_next[i] = sat_mag(tmag10_reg[i], tneg10_reg[i]);
            endcase
            if (zero10_reg)
                alt_next[i] = '0;
        end
        usediv_next = !zero10_reg && over && mode_reg != MODE_PROJ && mode_reg != MODE_BANG;
    end

    // s12: numerators of the scaling division
    logic             v12_reg;
    logic [2:0][57:0] num12_reg;
    logic [41:0]      den12_reg;
    d2_side_t         d2s12_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
        end
        else if (en)
        begin
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                alt11_reg[i]     <= alt_next[i];
                tmag11_reg[i]    <= tmag10_reg[i];
                num12_reg[i]     <= 58'(tmag11_reg[i]) * 58'(limj11_reg);
                d2s12_reg.alt[i] <= alt11_reg[i];
            end
            usediv11_reg     <= usediv_next;
            den11_reg        <= tj;
            limj11_reg       <= lj;
            tneg11_reg       <= tneg10_reg;
            zero11_reg       <= zero10_reg;
            den12_reg        <= den11_reg;
            d2s12_reg.zero   <= zero11_reg;
            d2s12_reg.usediv <= usediv11_reg;
            d2s12_reg.tneg   <= tneg11_reg;
        end
    end

    pipe_ctl_t        ctl3;
    logic             d2_vld;
    logic [2:0][15:0] q2;
    d2_side_t         d2s_out;

    assign ctl3.en    = en;
    assign ctl3.valid = v12_reg;

    bcdc_div #(
        .LANES (3),
        .NW    (58),
        .DW    (42),
        .QW    (16),
        .SW    ($bits(d2_side_t))
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl3),
        .num       (num12_reg),
        .den       (den12_reg),
        .side_in   (d2s12_reg),
        .out_valid (d2_vld),
        .quo       (q2),
        .side_out  (d2s_out)
    );

    // output word register
    logic [W_OUT_DATA-1:0] tdata_reg;
    logic                  tuser_reg;
    logic [W_OUT_DATA-1:0] tdata_next;

    always_comb
    begin
        logic [31:0] qv;
        for (int i = 0; i < 3; i++)
        begin
            qv = 32'(q2[i]);
            if (d2s_out.tneg[i])
                qv = -qv;
            tdata_next[32*i +: 32] = d2s_out.usediv ? qv : d2s_out.alt[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= d2s_out.zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

### design/bcdc_checker.sv
module bcdc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bcdc_pkg::W_OUT_DATA-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);
    import bcdc_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    // zero field forces zero moments
    a_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == {W_OUT_DATA{1'b0}})
        else $error("field_zero with nonzero moment");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a held output freezes the pipeline
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

bind b_cross_detumble_controller_top bcdc_checker u_bcdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
